[hdl/egpc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package egpc_pkg;

  localparam int MAX_COLS    = 512;
  localparam int MAX_ROWS    = 256;
  localparam int CELL_WIDTH  = 2;
  localparam int CELL_HEIGHT = 4;

  localparam int COL_W = 9;
  localparam int ROW_W = 8;
  localparam int STR_W = 11;
  localparam int GAP_W = 6;
  localparam int IDX_W = 3;
  localparam int CFG_W = 11;
  localparam int DX_W  = 10;
  localparam int Q_W   = 19;
  localparam int S_W   = 40;
  localparam int R_W   = 20;
  localparam int C_W   = 17;
  localparam int RB_W  = 9;
  localparam int PLO_W = 34;
  localparam int PHI_W = 37;

  localparam logic [STR_W-1:0] STR_MIN = 11'd128;
  localparam logic [STR_W-1:0] STR_MAX = 11'd1024;
  localparam logic [GAP_W-1:0] GAP_MIN = 6'd8;
  localparam logic [GAP_W-1:0] GAP_MAX = 6'd48;
  localparam logic [14:0]      TAN_LO  = 15'd27146;
  localparam logic [17:0]      TAN_HI  = 18'd158218;
  localparam logic [S_W-1:0]   S_SMALL = 40'd5899;

  localparam int N_DIV   = Q_W;
  localparam int N_SQRT  = R_W;
  localparam int N_CDIV  = C_W;
  localparam int N_MOD   = RB_W;
  localparam int ST_MUL  = N_DIV + 1;
  localparam int ST_SQ0  = ST_MUL + 1;
  localparam int ST_C0   = ST_SQ0 + N_SQRT;
  localparam int ST_FIN  = ST_C0 + N_CDIV;
  localparam int LATENCY = ST_FIN + 1;

  typedef enum logic [IDX_W-1:0] {
    REG_CENTER_COL = 3'd0,
    REG_CENTER_ROW = 3'd1,
    REG_STRETCH_X  = 3'd2,
    REG_STRETCH_Y  = 3'd3,
    REG_RING_GAP   = 3'd4,
    REG_HYP_EN     = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    GLYPH_NONE  = 3'd0,
    GLYPH_DASH  = 3'd1,
    GLYPH_BSL   = 3'd2,
    GLYPH_BAR   = 3'd3,
    GLYPH_SLASH = 3'd4,
    GLYPH_PLUS  = 3'd5
  } glyph_t;

  typedef struct packed {
    logic              oob;
    logic              u_neg;
    logic              v_neg;
    logic              hen;
    logic [STR_W-1:0]  sx;
    logic [STR_W-1:0]  sy;
    logic [GAP_W-1:0]  gap;
    logic [STR_W:0]    ru;
    logic [STR_W:0]    rv;
    logic [Q_W-1:0]    du;
    logic [Q_W-1:0]    dv;
    logic [Q_W-1:0]    au;
    logic [Q_W-1:0]    av;
    logic [S_W-1:0]    s;
    logic              too_close;
    logic [R_W+2:0]    sr;
    logic [R_W-1:0]    r;
    logic [PLO_W-1:0]  plo;
    logic [PHI_W-1:0]  phi;
    logic [GAP_W-1:0]  rg;
    logic [RB_W-1:0]   rb;
    logic [R_W:0]      cr;
    logic [C_W-1:0]    cb;
    logic [C_W-1:0]    c;
  } item_t;

  typedef struct packed {
    glyph_t glyph;
    logic   colour;
  } res_t;

  function automatic item_t div_step(item_t x);
    item_t y;
    logic [STR_W:0] tu;
    logic [STR_W:0] tv;
    y  = x;
    tu = {x.ru[STR_W-1:0], x.du[Q_W-1]};
    tv = {x.rv[STR_W-1:0], x.dv[Q_W-1]};
    if (tu >= {1'b0, x.sx}) begin
      y.ru = tu - {1'b0, x.sx};
      y.au = {x.au[Q_W-2:0], 1'b1};
    end else begin
      y.ru = tu;
      y.au = {x.au[Q_W-2:0], 1'b0};
    end
    if (tv >= {1'b0, x.sy}) begin
      y.rv = tv - {1'b0, x.sy};
      y.av = {x.av[Q_W-2:0], 1'b1};
    end else begin
      y.rv = tv;
      y.av = {x.av[Q_W-2:0], 1'b0};
    end
    y.du = {x.du[Q_W-2:0], 1'b0};
    y.dv = {x.dv[Q_W-2:0], 1'b0};
    return y;
  endfunction

  function automatic item_t mul_step(item_t x);
    item_t y;
    logic [2*Q_W-1:0] pu;
    logic [2*Q_W-1:0] pv;
    y           = x;
    pu          = x.au * x.au;
    pv          = x.av * x.av;
    y.s         = S_W'(pu) + S_W'(pv);
    y.too_close = (y.s < S_SMALL);
    y.plo       = x.au * TAN_LO;
    y.phi       = x.au * TAN_HI;
    y.u_neg     = x.u_neg & (|x.au);
    y.v_neg     = x.v_neg & (|x.av);
    y.sr        = '0;
    y.r         = '0;
    return y;
  endfunction

  function automatic item_t sqrt_step(item_t x);
    item_t y;
    logic [R_W+2:0] t;
    logic [R_W+2:0] trial;
    y     = x;
    t     = {x.sr[R_W:0], x.s[S_W-1 -: 2]};
    trial = {1'b0, x.r, 2'b01};
    if (t >= trial) begin
      y.sr = t - trial;
      y.r  = {x.r[R_W-2:0], 1'b1};
    end else begin
      y.sr = t;
      y.r  = {x.r[R_W-2:0], 1'b0};
    end
    y.s = {x.s[S_W-3:0], 2'b00};
    return y;
  endfunction

  function automatic item_t c_step(item_t x, logic first, logic do_mod);
    item_t y;
    logic [R_W:0]   t;
    logic [GAP_W:0] tg;
    y = x;
    if (first) begin
      y.rg = {3'b000, x.r[R_W-1 -: 3]};
      y.rb = x.r[R_W-4 -: RB_W];
      y.cr = {3'b000, x.au[Q_W-1:1]};
      y.cb = {x.au[0], 16'h0000};
      y.c  = '0;
    end
    if (do_mod) begin
      tg = {y.rg, y.rb[RB_W-1]};
      if (tg >= {1'b0, y.gap}) begin
        y.rg = GAP_W'(tg - {1'b0, y.gap});
      end else begin
        y.rg = GAP_W'(tg);
      end
      y.rb = {y.rb[RB_W-2:0], 1'b0};
    end
    t = {y.cr[R_W-1:0], y.cb[C_W-1]};
    if (t >= {1'b0, y.r}) begin
      y.cr = t - {1'b0, y.r};
      y.c  = {y.c[C_W-2:0], 1'b1};
    end else begin
      y.cr = t;
      y.c  = {y.c[C_W-2:0], 1'b0};
    end
    y.cb = {y.cb[C_W-2:0], 1'b0};
    return y;
  endfunction

  function automatic logic [1:0] mod3(logic [4:0] q);
    logic [4:0] v;
    v = q;
    for (int i = 0; i < 8; i++) begin
      if (v >= 5'd3) begin
        v = v - 5'd3;
      end
    end
    return v[1:0];
  endfunction

  function automatic res_t fin_step(item_t x);
    res_t           o;
    logic [13:0]    m;
    logic [21:0]    mm;
    logic [21:0]    per;
    logic [20:0]    p;
    logic [17:0]    h;
    logic [34:0]    avs;
    logic           ring;
    logic           hyp;
    glyph_t         slope;
    m    = {x.rg, x.r[7:0]};
    mm   = 22'(m) * 22'd100;
    per  = 22'(x.gap) << 8;
    ring = (mm < per * 22'd7) || (mm > per * 22'd93);
    p    = 21'(x.c) * 21'd25;
    h    = {mod3(p[20:16]), p[15:0]};
    hyp  = x.hen && ((h < 18'd32768) || (h > 18'd163840));
    avs  = {x.av, 16'h0000};
    if (avs < {1'b0, x.plo}) begin
      slope = GLYPH_DASH;
    end else if ({2'b00, avs} >= x.phi) begin
      slope = GLYPH_BAR;
    end else if (x.u_neg == x.v_neg) begin
      slope = GLYPH_BSL;
    end else begin
      slope = GLYPH_SLASH;
    end
    if (x.oob || x.too_close || (!ring && !hyp)) begin
      o.glyph  = GLYPH_NONE;
      o.colour = 1'b0;
    end else if (ring && hyp) begin
      o.glyph  = GLYPH_PLUS;
      o.colour = 1'b1;
    end else begin
      o.glyph  = slope;
      o.colour = hyp;
    end
    return o;
  endfunction

endpackage
`default_nettype wire

[hdl/elliptic_grid_pixel_classifier.sv]
// Elliptic grid cell classifier.
// Input: a transaction is taken at a rising edge with start high and busy low;
// cell_col and cell_row are sampled there. busy is always low: a new cell can
// be issued on every clock.
// Output: result_valid is high for one cycle with glyph and colour_class; the
// receiver cannot stall, so results are simply emitted in input order.
// Throughput: one cell per clock.
// The depth is set by bit-serial pipelines: 19 stages of restoring division
// for u and v, one multiply stage, 20 stages of square root, 17 stages for the
// cosine ratio division (ring modulo shares its first 9), one decision stage.
// Configuration: cfg_valid/cfg_ready write channel, cfg_index selects the
// register, cfg_data holds the value; cfg_ready is always high. Write only
// while no cells are in flight.
// Reset: synchronous, clears the in-flight valid bits and loads the register
// defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module elliptic_grid_pixel_classifier
  import egpc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [COL_W-1:0] cell_col,
  input  wire logic [ROW_W-1:0] cell_row,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  output logic                  result_valid,
  output logic [2:0]            glyph,
  output logic                  colour_class
);

  logic [COL_W-1:0] center_col;
  logic [ROW_W-1:0] center_row;
  logic [STR_W-1:0] stretch_x;
  logic [STR_W-1:0] stretch_y;
  logic [GAP_W-1:0] ring_gap;
  logic             hyperbola_enable;

  item_t        in_item;
  item_t        pipe [0:ST_FIN-1];
  logic [ST_FIN:0] vld;
  res_t         fo;
  logic [COL_W-1:0] ddx;
  logic [ROW_W-1:0] ddy;
  logic [DX_W-1:0]  adx;
  logic [DX_W-1:0]  ady;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_col       <= '0;
      center_row       <= '0;
      stretch_x        <= 11'd410;
      stretch_y        <= 11'd256;
      ring_gap         <= 6'd20;
      hyperbola_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        REG_CENTER_COL: center_col       <= cfg_data[COL_W-1:0];
        REG_CENTER_ROW: center_row       <= cfg_data[ROW_W-1:0];
        REG_STRETCH_X:  stretch_x        <= cfg_data[STR_W-1:0];
        REG_STRETCH_Y:  stretch_y        <= cfg_data[STR_W-1:0];
        REG_RING_GAP:   ring_gap         <= cfg_data[GAP_W-1:0];
        REG_HYP_EN:     hyperbola_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_item       = '0;
    in_item.oob   = ({1'b0, cell_col} >= (COL_W+1)'(MAX_COLS)) ||
                    ((9'(cell_row) + 9'd1) >= 9'(MAX_ROWS));
    in_item.u_neg = cell_col < center_col;
    in_item.v_neg = cell_row < center_row;
    ddx = in_item.u_neg ? center_col - cell_col : cell_col - center_col;
    ddy = in_item.v_neg ? center_row - cell_row : cell_row - center_row;
    adx = DX_W'(ddx) * DX_W'(CELL_WIDTH);
    ady = DX_W'(ddy) * DX_W'(CELL_HEIGHT);
    in_item.hen = hyperbola_enable;
    in_item.sx  = (stretch_x < STR_MIN) ? STR_MIN :
                  (stretch_x > STR_MAX) ? STR_MAX : stretch_x;
    in_item.sy  = (stretch_y < STR_MIN) ? STR_MIN :
                  (stretch_y > STR_MAX) ? STR_MAX : stretch_y;
    in_item.gap = (ring_gap < GAP_MIN) ? GAP_MIN :
                  (ring_gap > GAP_MAX) ? GAP_MAX : ring_gap;
    in_item.ru  = (STR_W+1)'(adx >> (Q_W-16));
    in_item.rv  = (STR_W+1)'(ady >> (Q_W-16));
    in_item.du  = Q_W'({adx, 16'h0000});
    in_item.dv  = Q_W'({ady, 16'h0000});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[ST_FIN-1:0], start & ~busy};
    end
  end

  always_ff @(posedge clk) begin
    pipe[0] <= in_item;
  end

  for (genvar k = 1; k < ST_FIN; k++) begin : g_st
    if (k <= N_DIV) begin : g_div
      always_ff @(posedge clk) begin
        pipe[k] <= div_step(pipe[k-1]);
      end
    end else if (k == ST_MUL) begin : g_mul
      always_ff @(posedge clk) begin
        pipe[k] <= mul_step(pipe[k-1]);
      end
    end else if (k < ST_C0) begin : g_sqrt
      always_ff @(posedge clk) begin
        pipe[k] <= sqrt_step(pipe[k-1]);
      end
    end else begin : g_cdiv
      always_ff @(posedge clk) begin
        pipe[k] <= c_step(pipe[k-1], k == ST_C0, k < ST_C0 + N_MOD);
      end
    end
  end

  assign fo = fin_step(pipe[ST_FIN-1]);

  always_ff @(posedge clk) begin
    glyph        <= fo.glyph;
    colour_class <= fo.colour;
  end

  assign result_valid = vld[ST_FIN];

endmodule
`default_nettype wire

[hdl/egpc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module egpc_checker
  import egpc_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       result_valid,
  input wire logic [2:0] glyph,
  input wire logic       colour_class
);

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(LATENCY) result_valid)
    else $error("result missing after fixed latency");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result strobe right after reset");

  a_none_colour: assert property (@(posedge clk) disable iff (rst)
    (result_valid && glyph == GLYPH_NONE) |-> !colour_class)
    else $error("colour set on empty glyph");

  a_plus_colour: assert property (@(posedge clk) disable iff (rst)
    (result_valid && glyph == GLYPH_PLUS) |-> colour_class)
    else $error("plus glyph without hyperbola colour");

  a_glyph_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (glyph <= GLYPH_PLUS))
    else $error("glyph code out of range");

endmodule

bind elliptic_grid_pixel_classifier egpc_checker u_egpc_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .glyph        (glyph),
  .colour_class (colour_class)
);
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import egpc_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam logic [IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] IDX_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [2:0] glyph;
    logic       colour;
  } cell_res_t;

  typedef struct {
    int unsigned col;
    int unsigned row;
    bit          fixed;
    cell_res_t   res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [COL_W-1:0] cell_col = '0;
  logic [ROW_W-1:0] cell_row = '0;
  logic cfg_valid = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic busy, cfg_ready, result_valid, colour_class;
  logic [2:0] glyph;

  // register shadow
  longint unsigned m_ccol, m_crow, m_sx, m_sy, m_gap, m_hen;

  cell_res_t pending[$];
  bit        use_fixed = 1'b0;
  cell_res_t fixed_val;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int          idle_pct = 0;

  elliptic_grid_pixel_classifier u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cell_col(cell_col), .cell_row(cell_row),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_valid(result_valid), .glyph(glyph), .colour_class(colour_class)
  );

  always #4 clk = ~clk;

  function automatic longint unsigned clampv(longint unsigned x, longint unsigned lo,
                                             longint unsigned hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic cell_res_t classify_cell(longint unsigned col, longint unsigned row);
    cell_res_t o;
    longint unsigned sx, sy, gap, adx, ady, au, av, s, r, per, m, c, h;
    bit un, vn, ring, hyp;
    glyph_t slope;
    o = '0;
    if (col >= MAX_COLS || row + 1 >= MAX_ROWS) return o;
    sx = clampv(m_sx, 128, 1024);
    sy = clampv(m_sy, 128, 1024);
    gap = clampv(m_gap, 8, 48);
    un = col < m_ccol;
    vn = row < m_crow;
    adx = (un ? m_ccol - col : col - m_ccol) * CELL_WIDTH;
    ady = (vn ? m_crow - row : row - m_crow) * CELL_HEIGHT;
    au = (adx << 16) / sx;
    av = (ady << 16) / sy;
    if (au == 0) un = 1'b0;
    if (av == 0) vn = 1'b0;
    s = au * au + av * av;
    if (100 * s < 9 * 65536) return o;
    r = isqrt(s);
    per = gap * 256;
    m = r % per;
    ring = (100 * m < 7 * per) || (100 * m > 93 * per);
    hyp = 1'b0;
    if (m_hen != 0 && r != 0) begin
      c = (au << 16) / r;
      h = (25 * c) % 196608;
      hyp = (h < 32768) || (h > 163840);
    end
    if (!ring && !hyp) return o;
    if ((av << 16) < 27146 * au) slope = GLYPH_DASH;
    else if ((av << 16) >= 158218 * au) slope = GLYPH_BAR;
    else slope = (un == vn) ? GLYPH_BSL : GLYPH_SLASH;
    if (ring && hyp) begin
      o.glyph = GLYPH_PLUS;
      o.colour = 1'b1;
    end else begin
      o.glyph = slope;
      o.colour = hyp;
    end
    return o;
  endfunction

  always @(posedge clk) begin
    cell_res_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("*** FAILED ***");
      $finish;
    end
    if (rst) begin
      m_ccol = 0; m_crow = 0; m_sx = 410; m_sy = 256; m_gap = 20; m_hen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CENTER_COL: m_ccol = 64'(cfg_data & 11'h1FF);
          REG_CENTER_ROW: m_crow = 64'(cfg_data & 11'h0FF);
          REG_STRETCH_X:  m_sx = 64'(cfg_data);
          REG_STRETCH_Y:  m_sy = 64'(cfg_data);
          REG_RING_GAP:   m_gap = 64'(cfg_data & 11'h03F);
          REG_HYP_EN:     m_hen = 64'(cfg_data & 11'h001);
          default: ;
        endcase
      end
      if (result_valid) begin
        if (pending.size() == 0) begin
          $display("%0t unexpected result glyph=%0d colour=%0d", $time, glyph, colour_class);
          errors++;
        end else begin
          e = pending.pop_front();
          if (glyph !== e.glyph)
            $display("%0t glyph mismatch: expected %0d actual %0d", $time, e.glyph, glyph);
          if (colour_class !== e.colour)
            $display("%0t colour mismatch: expected %0d actual %0d", $time, e.colour,
                     colour_class);
          if (glyph !== e.glyph || colour_class !== e.colour) errors++;
        end
      end
      if (start && !busy) begin
        e = classify_cell(64'(cell_col), 64'(cell_row));
        if (use_fixed && e !== fixed_val) begin
          $display("%0t predictor disagrees with table: expected %0d/%0d got %0d/%0d",
                   $time, fixed_val.glyph, fixed_val.colour, e.glyph, e.colour);
          errors++;
        end
        pending.push_back(use_fixed ? fixed_val : e);
      end
    end
  end

  task automatic send_cell(input int unsigned col, input int unsigned row);
    int gap;
    start <= 1'b1;
    cell_col <= COL_W'(col);
    cell_row <= ROW_W'(row);
    do @(negedge clk); while (busy);
    @(posedge clk);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(val);
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic random_cfg;
    write_reg(REG_CENTER_COL, $urandom_range(511));
    write_reg(REG_CENTER_ROW, $urandom_range(255));
    write_reg(REG_STRETCH_X, $urandom_range(128, 1024));
    write_reg(REG_STRETCH_Y, $urandom_range(128, 1024));
    write_reg(REG_RING_GAP, $urandom_range(8, 48));
    write_reg(REG_HYP_EN, $urandom_range(1));
  endtask

  task automatic random_cells(input int n);
    int unsigned col, row;
    for (int i = 0; i < n; i++) begin
      col = $urandom_range(511);
      row = ($urandom_range(19) == 0) ? 255 : $urandom_range(254);
      if ($urandom_range(3) == 0) begin
        col = 32'((m_ccol + $urandom_range(40) - 20) & 64'h1FF);
        row = 32'((m_crow + $urandom_range(20) - 10) & 64'hFF);
      end
      send_cell(col, row);
    end
  endtask

  dir_row_t dir_tab[] = '{
    '{0, 0, 1, '{GLYPH_NONE, 1'b0}},
    '{0, 255, 1, '{GLYPH_NONE, 1'b0}},
    '{511, 255, 1, '{GLYPH_NONE, 1'b0}},
    '{300, 255, 1, '{GLYPH_NONE, 1'b0}},
    '{511, 0, 0, '{GLYPH_NONE, 1'b0}},
    '{0, 254, 0, '{GLYPH_NONE, 1'b0}},
    '{511, 254, 0, '{GLYPH_NONE, 1'b0}},
    '{1, 0, 0, '{GLYPH_NONE, 1'b0}},
    '{0, 1, 0, '{GLYPH_NONE, 1'b0}},
    '{41, 0, 0, '{GLYPH_NONE, 1'b0}},
    '{0, 5, 0, '{GLYPH_NONE, 1'b0}},
    '{20, 20, 0, '{GLYPH_NONE, 1'b0}},
    '{100, 40, 0, '{GLYPH_NONE, 1'b0}},
    '{256, 128, 0, '{GLYPH_NONE, 1'b0}},
    '{170, 85, 0, '{GLYPH_NONE, 1'b0}},
    '{85, 170, 0, '{GLYPH_NONE, 1'b0}}
  };

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idle_pct = 31;
    foreach (dir_tab[i]) begin
      use_fixed <= dir_tab[i].fixed;
      fixed_val <= dir_tab[i].res;
      send_cell(dir_tab[i].col, dir_tab[i].row);
    end
    start <= 1'b0;
    @(posedge clk);
    use_fixed <= 1'b0;
    drain();

    // out-of-range register values and spare indexes
    write_reg(REG_CENTER_COL, 511);
    write_reg(REG_CENTER_ROW, 254);
    write_reg(REG_STRETCH_X, 0);
    write_reg(REG_STRETCH_Y, 2047);
    write_reg(REG_RING_GAP, 0);
    write_reg(REG_HYP_EN, 1);
    write_reg(IDX_SPARE_LO, 2047);
    write_reg(IDX_SPARE_HI, 0);
    send_cell(511, 254);
    send_cell(0, 0);
    send_cell(0, 254);
    send_cell(511, 0);
    send_cell(255, 127);
    random_cells(200);
    drain();

    write_reg(REG_CENTER_COL, 0);
    write_reg(REG_CENTER_ROW, 0);
    write_reg(REG_STRETCH_X, 2047);
    write_reg(REG_STRETCH_Y, 0);
    write_reg(REG_RING_GAP, 63);
    write_reg(REG_HYP_EN, 0);
    random_cells(150);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 31 : (ph == 1) ? 83 : 0;
      for (int k = 0; k < 3; k++) begin
        random_cfg();
        random_cells(142);
        drain();
      end
    end

    write_reg(REG_CENTER_COL, 256);
    write_reg(REG_CENTER_ROW, 128);
    write_reg(REG_STRETCH_X, 128);
    write_reg(REG_STRETCH_Y, 1024);
    write_reg(REG_RING_GAP, 8);
    write_reg(REG_HYP_EN, 1);
    random_cells(150);
    drain();
    write_reg(REG_STRETCH_X, 1024);
    write_reg(REG_STRETCH_Y, 128);
    write_reg(REG_RING_GAP, 48);
    random_cells(150);
    drain();

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
